// File: hdl/gbia_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// grouped bitmap allocator. No dependencies.
`timescale 1ns / 1ps

package gbia_pkg;

    localparam int MAX_GROUPS      = 64;
    localparam int MAX_EPG         = 8192;
    localparam int WORD_W          = 64;
    localparam int WORDS_PER_GROUP = MAX_EPG / WORD_W;
    localparam int TOTAL_WORDS     = MAX_GROUPS * WORDS_PER_GROUP;

    localparam int GRP_W   = $clog2(MAX_GROUPS);
    localparam int WIDX_W  = $clog2(WORDS_PER_GROUP);
    localparam int BOFS_W  = $clog2(WORD_W);
    localparam int BIT_W   = WIDX_W + BOFS_W;
    localparam int ADDR_W  = GRP_W + WIDX_W;
    localparam int EPG_W   = 14;
    localparam int NG_W    = 7;
    localparam int CNT_W   = 14;
    localparam int NUM_W   = 20;
    localparam int ST_W    = 2;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 14;

    localparam int DIV_STEPS = NUM_W;
    localparam int DIVCNT_W  = $clog2(DIV_STEPS + 1);

    typedef logic [ST_W-1:0] status_t;

    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_NO_SPACE = 2'd1;
    localparam status_t ST_DUP      = 2'd2;
    localparam status_t ST_RANGE    = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_EPG = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NG  = 1'd1;

    typedef struct packed {
        logic    clear;
        logic    accept;
        logic    gscan;
        logic    div_take;
        logic    gcapture;
        logic    wscan;
        logic    commit;
        logic    fail;
        logic    fail_show;
        status_t fail_code;
        logic    out_load;
    } gbia_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic in_free;
        logic in_free_q;
        logic div_busy;
        logic range_bad;
        logic g_found;
        logic g_done;
        logic w_found;
        logic w_done;
        logic bit_set;
        logic out_busy;
    } gbia_stat_t;

endpackage

// File: hdl/gbia_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on gbia_pkg.
`timescale 1ns / 1ps

module gbia_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [gbia_pkg::NUM_W-1:0]    dividend,
    input  logic [gbia_pkg::EPG_W-1:0]    divisor,
    output logic                          busy,
    output logic [gbia_pkg::NUM_W-1:0]    quotient,
    output logic [gbia_pkg::EPG_W-1:0]    remainder
);
    import gbia_pkg::*;

    logic [DIVCNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0]    q_reg;
    logic [EPG_W-1:0]    r_reg;
    logic [EPG_W-1:0]    d_reg;
    logic [EPG_W:0]      trial;
    logic [EPG_W:0]      diff;
    logic                ge;

    assign trial = {r_reg, q_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, d_reg};
    assign ge    = trial >= {1'b0, d_reg};

    assign busy      = cnt_reg != '0;
    assign quotient  = q_reg;
    assign remainder = r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= DIVCNT_W'(DIV_STEPS);
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy)
        begin
            q_reg <= {q_reg[NUM_W-2:0], ge};
            r_reg <= ge ? diff[EPG_W-1:0] : trial[EPG_W-1:0];
        end
    end

endmodule

// File: hdl/gbia_dp.sv
// Datapath: config registers, bitmap and group count memories, scan
// pipelines, divider, counters and output word register. Depends on gbia_pkg, gbia_div.
`timescale 1ns / 1ps

module gbia_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wen,
    input  logic [gbia_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gbia_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              operation,
    input  logic [gbia_pkg::NUM_W-1:0]        entry_number,
    input  logic                              is_directory,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic [gbia_pkg::ST_W-1:0]         status,
    output logic [gbia_pkg::NUM_W-1:0]        result_number,
    output logic [gbia_pkg::GRP_W-1:0]        group_index,
    output logic [gbia_pkg::CNT_W-1:0]        group_free_count,
    output logic [gbia_pkg::CNT_W-1:0]        group_dir_count,
    output logic [gbia_pkg::NUM_W-1:0]        total_free_count,
    input  gbia_pkg::gbia_cmd_t               cmd,
    output gbia_pkg::gbia_stat_t              stat
);
    import gbia_pkg::*;

    // config
    logic [EPG_W-1:0] epg_reg;
    logic [NG_W-1:0]  ng_reg;
    logic [EPG_W-1:0] epg_eff;
    logic [NG_W-1:0]  ng_eff;

    // memories
    logic [WORD_W-1:0] bits_mem [TOTAL_WORDS];
    logic [CNT_W-1:0]  used_mem [MAX_GROUPS];
    logic [CNT_W-1:0]  dirs_mem [MAX_GROUPS];
    logic [WORD_W-1:0] bits_rdata_reg;
    logic [CNT_W-1:0]  used_rdata_reg;
    logic [CNT_W-1:0]  dirs_rdata_reg;
    logic [ADDR_W-1:0] bits_raddr;
    logic [ADDR_W-1:0] bits_waddr;
    logic [WORD_W-1:0] bits_wdata;
    logic [GRP_W-1:0]  cnt_raddr;
    logic [GRP_W-1:0]  cnt_waddr;
    logic [CNT_W-1:0]  used_wdata;
    logic [CNT_W-1:0]  dirs_wdata;
    logic              mem_we;

    // item state
    logic [ADDR_W-1:0] clr_addr_reg;
    logic              op_reg;
    logic              dir_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [GRP_W-1:0]  g_reg;
    logic [BIT_W-1:0]  b_reg;
    logic [CNT_W-1:0]  used_reg;
    logic [CNT_W-1:0]  dirs_reg;
    logic [NUM_W-1:0]  tu_reg;
    logic [WORD_W-1:0] word_reg;
    status_t           st_reg;
    logic              show_reg;
    logic [NUM_W-1:0]  prod_reg;
    logic [NUM_W-1:0]  cap_reg;

    // scan pipelines
    logic [GRP_W:0]    gi_reg;
    logic              grv_reg;
    logic [GRP_W-1:0]  gcw_reg;
    logic [WIDX_W:0]   wi_reg;
    logic              wrv_reg;
    logic [WIDX_W-1:0] wcw_reg;
    logic              g_issue;
    logic              w_issue;

    logic [EPG_W-1:0]  span;
    logic [WORD_W-1:0] valid_mask;
    logic [WORD_W-1:0] cand;
    logic [WORD_W-1:0] lowest;
    logic [BOFS_W-1:0] low_idx;
    logic [WORD_W-1:0] bit_mask_b;

    // divider
    logic [NUM_W-1:0]  quotient;
    logic [EPG_W-1:0]  remainder;
    logic              div_busy;

    // arithmetic
    logic [EPG_W+NG_W-1:0]  cap_full;
    logic [GRP_W+EPG_W-1:0] prod_full;
    logic [NUM_W-1:0]       alloc_num;
    logic [CNT_W-1:0]       used_new;
    logic [CNT_W-1:0]       dirs_new;
    logic [NUM_W-1:0]       tu_new;
    logic [CNT_W-1:0]       grp_free;
    logic [NUM_W-1:0]       tot_free;
    logic                   is_alloc;

    logic                   out_valid_reg;

    assign epg_eff = (epg_reg == '0) ? EPG_W'(1) :
                     (epg_reg > EPG_W'(MAX_EPG)) ? EPG_W'(MAX_EPG) : epg_reg;
    assign ng_eff  = (ng_reg == '0) ? NG_W'(1) :
                     (ng_reg > NG_W'(MAX_GROUPS)) ? NG_W'(MAX_GROUPS) : ng_reg;

    gbia_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.accept),
        .dividend  (entry_number - NUM_W'(1)),
        .divisor   (epg_eff),
        .busy      (div_busy),
        .quotient  (quotient),
        .remainder (remainder)
    );

    // addressing
    assign cnt_raddr  = cmd.gscan ? gi_reg[GRP_W-1:0] : g_reg;
    assign bits_raddr = cmd.wscan ? {g_reg, wi_reg[WIDX_W-1:0]}
                                  : {g_reg, b_reg[BIT_W-1:BOFS_W]};
    assign mem_we     = cmd.clear || cmd.commit;
    assign bits_waddr = cmd.clear ? clr_addr_reg : {g_reg, b_reg[BIT_W-1:BOFS_W]};
    assign bits_wdata = cmd.clear ? '0 : word_reg;
    assign cnt_waddr  = cmd.clear ? clr_addr_reg[GRP_W-1:0] : g_reg;
    assign used_wdata = cmd.clear ? '0 : used_new;
    assign dirs_wdata = cmd.clear ? '0 : dirs_new;

    // scans
    assign g_issue = gi_reg < ng_eff;
    assign w_issue = {wi_reg, {BOFS_W{1'b0}}} < epg_eff;
    assign span    = epg_eff - {1'b0, wcw_reg, {BOFS_W{1'b0}}};

    always_comb
    begin
        valid_mask = (span >= EPG_W'(WORD_W)) ? '1 : ~({WORD_W{1'b1}} << span[BOFS_W-1:0]);
        cand       = ~bits_rdata_reg & valid_mask;
        lowest     = cand & (~cand + WORD_W'(1));
        low_idx    = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            if (lowest[i])
            begin
                low_idx = low_idx | BOFS_W'(i);
            end
        end
    end

    assign bit_mask_b = WORD_W'(1) << b_reg[BOFS_W-1:0];

    // counts
    assign is_alloc  = op_reg == OP_ALLOC;
    assign cap_full  = epg_eff * ng_eff;
    assign prod_full = g_reg * epg_eff;
    assign alloc_num = prod_reg + NUM_W'(b_reg) + NUM_W'(1);

    always_comb
    begin
        if (is_alloc)
        begin
            used_new = used_reg + CNT_W'(1);
            tu_new   = tu_reg + NUM_W'(1);
            dirs_new = (dir_reg && dirs_reg < CNT_W'(MAX_EPG)) ? dirs_reg + CNT_W'(1) : dirs_reg;
        end
        else
        begin
            used_new = (used_reg != '0) ? used_reg - CNT_W'(1) : used_reg;
            tu_new   = (tu_reg != '0) ? tu_reg - NUM_W'(1) : tu_reg;
            dirs_new = (dir_reg && dirs_reg != '0) ? dirs_reg - CNT_W'(1) : dirs_reg;
        end
    end

    assign grp_free = (epg_eff > used_reg) ? epg_eff - used_reg : '0;
    assign tot_free = (cap_reg > tu_reg) ? cap_reg - tu_reg : '0;

    // status to controller
    assign stat.clr_last  = clr_addr_reg == '1;
    assign stat.in_free   = operation == OP_FREE;
    assign stat.in_free_q = op_reg == OP_FREE;
    assign stat.div_busy  = div_busy;
    assign stat.range_bad = (num_reg == '0) || (quotient >= NUM_W'(ng_eff));
    assign stat.g_found   = grv_reg && (epg_eff > used_rdata_reg);
    assign stat.g_done    = !grv_reg && !g_issue;
    assign stat.w_found   = wrv_reg && (cand != '0);
    assign stat.w_done    = !wrv_reg && !w_issue;
    assign stat.bit_set   = (bits_rdata_reg & bit_mask_b) != '0;
    assign stat.out_busy  = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;

    // memories
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            bits_mem[bits_waddr] <= bits_wdata;
        end
        bits_rdata_reg <= bits_mem[bits_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            used_mem[cnt_waddr] <= used_wdata;
        end
        used_rdata_reg <= used_mem[cnt_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            dirs_mem[cnt_waddr] <= dirs_wdata;
        end
        dirs_rdata_reg <= dirs_mem[cnt_raddr];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epg_reg       <= EPG_W'(MAX_EPG);
            ng_reg        <= NG_W'(1);
            clr_addr_reg  <= '0;
            tu_reg        <= '0;
            out_valid_reg <= 1'b0;
            gi_reg        <= '0;
            grv_reg       <= 1'b0;
            wi_reg        <= '0;
            wrv_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                case (cfg_index)
                    REG_EPG: epg_reg <= cfg_data[EPG_W-1:0];
                    REG_NG:  ng_reg  <= cfg_data[NG_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.clear)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.commit)
            begin
                tu_reg <= tu_new;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.accept)
            begin
                gi_reg  <= '0;
                grv_reg <= 1'b0;
            end
            else if (cmd.gscan)
            begin
                grv_reg <= g_issue;
                if (g_issue)
                begin
                    gi_reg <= gi_reg + 1'b1;
                end
            end
            if (cmd.gcapture)
            begin
                wi_reg  <= '0;
                wrv_reg <= 1'b0;
            end
            else if (cmd.wscan)
            begin
                wrv_reg <= w_issue;
                if (w_issue)
                begin
                    wi_reg <= wi_reg + 1'b1;
                end
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_full[NUM_W-1:0];
        cap_reg  <= cap_full[NUM_W-1:0];
        if (cmd.gscan)
        begin
            gcw_reg <= gi_reg[GRP_W-1:0];
        end
        if (cmd.wscan)
        begin
            wcw_reg <= wi_reg[WIDX_W-1:0];
        end
        if (cmd.accept)
        begin
            op_reg  <= operation;
            dir_reg <= is_directory;
            num_reg <= entry_number;
        end
        if (cmd.gscan && stat.g_found)
        begin
            g_reg <= gcw_reg;
        end
        if (cmd.div_take)
        begin
            g_reg <= quotient[GRP_W-1:0];
            b_reg <= remainder[BIT_W-1:0];
        end
        if (cmd.gcapture)
        begin
            used_reg <= used_rdata_reg;
            dirs_reg <= dirs_rdata_reg;
            word_reg <= bits_rdata_reg & ~bit_mask_b;
        end
        if (cmd.wscan && stat.w_found)
        begin
            b_reg    <= {wcw_reg, low_idx};
            word_reg <= bits_rdata_reg | lowest;
        end
        if (cmd.commit)
        begin
            used_reg <= used_new;
            dirs_reg <= dirs_new;
            num_reg  <= is_alloc ? alloc_num : num_reg;
            st_reg   <= ST_OK;
            show_reg <= 1'b1;
        end
        if (cmd.fail)
        begin
            num_reg  <= '0;
            st_reg   <= cmd.fail_code;
            show_reg <= cmd.fail_show;
        end
        if (cmd.out_load)
        begin
            status           <= st_reg;
            result_number    <= num_reg;
            group_index      <= show_reg ? g_reg : '0;
            group_free_count <= show_reg ? grp_free : '0;
            group_dir_count  <= show_reg ? dirs_reg : '0;
            total_free_count <= tot_free;
        end
    end

endmodule

// File: hdl/gbia_ctrl.sv
// Controller state machine: sequences clear pass, group scan, divide,
// bitmap scan, commit and output load. Depends on gbia_pkg.
`timescale 1ns / 1ps

module gbia_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  gbia_pkg::gbia_stat_t   stat,
    output gbia_pkg::gbia_cmd_t    cmd
);
    import gbia_pkg::*;

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_GSCAN = 9'b000000100,
        S_DIV   = 9'b000001000,
        S_GLOAD = 9'b000010000,
        S_GWAIT = 9'b000100000,
        S_WSCAN = 9'b001000000,
        S_WRITE = 9'b010000000,
        S_RESP  = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = state_reg == S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = stat.in_free ? S_DIV : S_GSCAN;
                end
            end
            S_GSCAN:
            begin
                cmd.gscan = 1'b1;
                if (stat.g_found)
                begin
                    state_next = S_GLOAD;
                end
                else if (stat.g_done)
                begin
                    cmd.fail      = 1'b1;
                    cmd.fail_code = ST_NO_SPACE;
                    state_next    = S_RESP;
                end
            end
            S_DIV:
            begin
                if (!stat.div_busy)
                begin
                    if (stat.range_bad)
                    begin
                        cmd.fail      = 1'b1;
                        cmd.fail_code = ST_RANGE;
                        state_next    = S_RESP;
                    end
                    else
                    begin
                        cmd.div_take = 1'b1;
                        state_next   = S_GLOAD;
                    end
                end
            end
            S_GLOAD:
            begin
                state_next = S_GWAIT;
            end
            S_GWAIT:
            begin
                cmd.gcapture = 1'b1;
                if (!stat.in_free_q)
                begin
                    state_next = S_WSCAN;
                end
                else if (stat.bit_set)
                begin
                    state_next = S_WRITE;
                end
                else
                begin
                    cmd.fail      = 1'b1;
                    cmd.fail_show = 1'b1;
                    cmd.fail_code = ST_DUP;
                    state_next    = S_RESP;
                end
            end
            S_WSCAN:
            begin
                cmd.wscan = 1'b1;
                if (stat.w_found)
                begin
                    state_next = S_WRITE;
                end
                else if (stat.w_done)
                begin
                    cmd.fail      = 1'b1;
                    cmd.fail_show = 1'b1;
                    cmd.fail_code = ST_NO_SPACE;
                    state_next    = S_RESP;
                end
            end
            S_WRITE:
            begin
                cmd.commit = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hdl/grouped_bitmap_inode_allocator.sv
// Grouped bitmap allocator, top level: controller plus datapath.
// Allocate: the group scan finds a group with free entries, then the bitmap scan finds
// the word holding the free bit; the time from accept to result word is bounded by both scans.
// Free: the divider first maps the entry number to group and bit. One item at a time.
// Reset: clearing pass over the bitmap and group counts, in_ready low.
`timescale 1ns / 1ps

module grouped_bitmap_inode_allocator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wen,
    input  logic [gbia_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gbia_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              operation,
    input  logic [gbia_pkg::NUM_W-1:0]        entry_number,
    input  logic                              is_directory,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [gbia_pkg::ST_W-1:0]         status,
    output logic [gbia_pkg::NUM_W-1:0]        result_number,
    output logic [gbia_pkg::GRP_W-1:0]        group_index,
    output logic [gbia_pkg::CNT_W-1:0]        group_free_count,
    output logic [gbia_pkg::CNT_W-1:0]        group_dir_count,
    output logic [gbia_pkg::NUM_W-1:0]        total_free_count
);
    import gbia_pkg::*;

    gbia_cmd_t  cmd;
    gbia_stat_t stat;

    gbia_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gbia_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wen          (cfg_wen),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .operation        (operation),
        .entry_number     (entry_number),
        .is_directory     (is_directory),
        .out_ready        (out_ready),
        .out_valid        (out_valid),
        .status           (status),
        .result_number    (result_number),
        .group_index      (group_index),
        .group_free_count (group_free_count),
        .group_dir_count  (group_dir_count),
        .total_free_count (total_free_count),
        .cmd              (cmd),
        .stat             (stat)
    );

endmodule
